// ===== src/kfi_pkg.sv =====
// Package: shared constants, opcodes and payload types of the keyframe pose interpolator.
`timescale 1ns / 1ps
package kfi_pkg;
   localparam int MAX_KEYS   = 16;
   localparam int KEY_BITS   = $clog2(MAX_KEYS);
   localparam int KCNT_BITS  = KEY_BITS + 1;
   localparam int COORD_BITS = 32;
   localparam int N_COORD    = 6;
   localparam int DUR_BITS   = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + DUR_BITS;
   localparam int MAG_BITS   = PROD_BITS - 1;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int STEP_BITS  = $clog2(MAG_BITS + 1);

   localparam logic [0:0] CSR_LOOP_ENABLE = 1'b0;
   localparam logic [0:0] CSR_KEY_COUNT   = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                    opcode;
      logic [3:0]                    key_index;
      logic [DUR_BITS-1:0]           key_duration;
      logic signed [COORD_BITS-1:0]  view_x;
      logic signed [COORD_BITS-1:0]  view_y;
      logic signed [COORD_BITS-1:0]  view_z;
      logic signed [COORD_BITS-1:0]  target_x;
      logic signed [COORD_BITS-1:0]  target_y;
      logic signed [COORD_BITS-1:0]  target_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  out_view_x;
      logic signed [COORD_BITS-1:0]  out_view_y;
      logic signed [COORD_BITS-1:0]  out_view_z;
      logic signed [COORD_BITS-1:0]  out_target_x;
      logic signed [COORD_BITS-1:0]  out_target_y;
      logic signed [COORD_BITS-1:0]  out_target_z;
      logic                          still_running;
   } rsp_type;

   typedef logic [N_COORD-1:0][COORD_BITS-1:0] row_type;
endpackage

// ===== src/kfi_front.sv =====
// Front end: accepts requests, drops unused opcodes and queues the rest for the back end.
`timescale 1ns / 1ps
module kfi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kfi_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output kfi_pkg::req_type cmd_data
);
   kfi_pkg::req_type q_mem[2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_mem[rd_ptr_ff];
   assign push      = req_valid && !req_stall &&
                      (req_data.opcode != kfi_pkg::OP_NONE);
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= req_data;
      end
   end
endmodule

// ===== src/kfi_back.sv =====
// Back end: keyframe table, animation counters, six divider lanes and the result register.
`timescale 1ns / 1ps
module kfi_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  kfi_pkg::req_type cmd_data,
   input  logic             csr_write_enable,
   input  logic [0:0]       csr_index,
   input  logic [4:0]       csr_write_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kfi_pkg::rsp_type rsp_data
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_OUT
   } state_type;

   localparam int KB = kfi_pkg::KEY_BITS;
   localparam int CB = kfi_pkg::COORD_BITS;
   localparam int DB = kfi_pkg::DUR_BITS;
   localparam int NB = kfi_pkg::KCNT_BITS;
   localparam int MB = kfi_pkg::MAG_BITS;
   localparam int PB = kfi_pkg::PROD_BITS;
   localparam int SB = kfi_pkg::SUM_BITS;
   localparam int TB = kfi_pkg::STEP_BITS;
   localparam int NC = kfi_pkg::N_COORD;

   kfi_pkg::row_type coord_mem[kfi_pkg::MAX_KEYS];
   logic [DB-1:0]    dur_mem[kfi_pkg::MAX_KEYS];
   kfi_pkg::row_type cur_row_ff, nxt_row_ff;
   logic [DB-1:0]    dur_rd_ff;

   state_type        state_ff, state_in;
   logic             loop_ff, loop_in;
   logic [NB-1:0]    kcnt_ff, kcnt_in;
   logic             active_ff, active_in;
   logic [KB-1:0]    cur_ff, cur_in;
   logic [KB-1:0]    nxt_ff, nxt_in;
   logic [DB-1:0]    frame_ff, frame_in;
   logic [TB-1:0]    step_ff, step_in;
   logic [DB-1:0]    dur_ff, dur_in;
   logic [NC-1:0]    neg_ff, neg_in;
   logic [MB-1:0]    num_ff[NC], num_in[NC];
   logic [DB-1:0]    rem_ff[NC], rem_in[NC];
   logic             rsp_valid_ff, rsp_valid_in;
   kfi_pkg::rsp_type rsp_ff, rsp_in;

   logic [NB-1:0]    n_keys;
   logic [KB-1:0]    cur_adj;
   logic             load_hit;

   logic signed [kfi_pkg::DIFF_BITS-1:0] diff;
   logic signed [PB-1:0]                 prod;
   logic [DB:0]                          trial;
   logic signed [SB-1:0]                 q_s, sum_s;
   logic [CB-1:0]                        sat[NC];
   logic [DB:0]                          frame_inc;
   logic [KB-1:0]                        cur_next;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign load_hit  = cmd_pop && (cmd_data.opcode == kfi_pkg::OP_LOAD);

   always_comb begin
      if (kcnt_ff == '0) begin
         n_keys = NB'(1);
      end else if (kcnt_ff > NB'(kfi_pkg::MAX_KEYS)) begin
         n_keys = NB'(kfi_pkg::MAX_KEYS);
      end else begin
         n_keys = kcnt_ff;
      end
      cur_adj = ({1'b0, cur_ff} >= n_keys) ? '0 : cur_ff;
   end

   always_comb begin
      state_in     = state_ff;
      loop_in      = loop_ff;
      kcnt_in      = kcnt_ff;
      active_in    = active_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      frame_in     = frame_ff;
      step_in      = step_ff;
      dur_in       = dur_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      diff         = '0;
      prod         = '0;
      trial        = '0;
      q_s          = '0;
      sum_s        = '0;
      frame_inc    = '0;
      cur_next     = '0;
      for (int j = 0; j < NC; j++) begin
         sat[j] = '0;
      end

      if (csr_write_enable) begin
         case (csr_index)
            kfi_pkg::CSR_LOOP_ENABLE: loop_in = csr_write_data[0];
            kfi_pkg::CSR_KEY_COUNT:   kcnt_in = csr_write_data[NB-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.opcode)
                  kfi_pkg::OP_START: begin
                     cur_in    = '0;
                     frame_in  = '0;
                     active_in = 1'b1;
                  end
                  kfi_pkg::OP_TICK: begin
                     if (active_ff) begin
                        cur_in   = cur_adj;
                        nxt_in   = ({1'b0, cur_adj} == n_keys - NB'(1)) ? '0
                                   : cur_adj + KB'(1);
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            dur_in = (dur_rd_ff == '0) ? DB'(1) : dur_rd_ff;
            for (int j = 0; j < NC; j++) begin
               diff = $signed({nxt_row_ff[j][CB-1], nxt_row_ff[j]})
                    - $signed({cur_row_ff[j][CB-1], cur_row_ff[j]});
               prod = diff * $signed({1'b0, frame_ff});
               neg_in[j] = prod[PB-1];
               num_in[j] = prod[PB-1] ? MB'(-prod) : MB'(prod);
               rem_in[j] = '0;
            end
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int j = 0; j < NC; j++) begin
               trial = {rem_ff[j], num_ff[j][MB-1]};
               if (trial >= {1'b0, dur_ff}) begin
                  rem_in[j] = DB'(trial - {1'b0, dur_ff});
                  num_in[j] = {num_ff[j][MB-2:0], 1'b1};
               end else begin
                  rem_in[j] = trial[DB-1:0];
                  num_in[j] = {num_ff[j][MB-2:0], 1'b0};
               end
            end
            step_in = step_ff + TB'(1);
            if (step_ff == TB'(MB - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int j = 0; j < NC; j++) begin
                  q_s   = neg_ff[j] ? -$signed({2'b00, num_ff[j]})
                                    : $signed({2'b00, num_ff[j]});
                  sum_s = $signed({{(SB-CB){cur_row_ff[j][CB-1]}}, cur_row_ff[j]}) + q_s;
                  if (sum_s > $signed(SB'({1'b0, {(CB-1){1'b1}}}))) begin
                     sat[j] = {1'b0, {(CB-1){1'b1}}};
                  end else if (sum_s < -$signed(SB'({1'b1, {(CB-1){1'b0}}}))) begin
                     sat[j] = {1'b1, {(CB-1){1'b0}}};
                  end else begin
                     sat[j] = sum_s[CB-1:0];
                  end
               end
               frame_inc = {1'b0, frame_ff} + (DB+1)'(1);
               cur_next  = ({1'b0, cur_ff} == n_keys - NB'(1)) ? '0 : cur_ff + KB'(1);
               if (frame_inc >= {1'b0, dur_ff}) begin
                  frame_in = '0;
                  cur_in   = cur_next;
                  if (!loop_ff && ({1'b0, cur_next} == n_keys - NB'(1))) begin
                     active_in = 1'b0;
                  end
               end else begin
                  frame_in = frame_inc[DB-1:0];
               end
               rsp_in.out_view_x    = sat[0];
               rsp_in.out_view_y    = sat[1];
               rsp_in.out_view_z    = sat[2];
               rsp_in.out_target_x  = sat[3];
               rsp_in.out_target_y  = sat[4];
               rsp_in.out_target_z  = sat[5];
               rsp_in.still_running = active_in;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_ff      <= 1'b0;
         kcnt_ff      <= NB'(1);
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loop_ff      <= loop_in;
         kcnt_ff      <= kcnt_in;
         active_ff    <= active_in;
         cur_ff       <= cur_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nxt_ff  <= nxt_in;
      step_ff <= step_in;
      dur_ff  <= dur_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         coord_mem[cmd_data.key_index[KB-1:0]] <= {cmd_data.target_z, cmd_data.target_y,
                                                   cmd_data.target_x, cmd_data.view_z,
                                                   cmd_data.view_y, cmd_data.view_x};
         dur_mem[cmd_data.key_index[KB-1:0]]   <= cmd_data.key_duration;
      end
      cur_row_ff <= coord_mem[cur_ff];
      nxt_row_ff <= coord_mem[nxt_ff];
      dur_rd_ff  <= dur_mem[nxt_ff];
   end
endmodule

// ===== src/keyframe_pose_interpolator_top.sv =====
// Top level of the keyframe pose interpolator.
//   channel | ports                                   | direction
//   request | req_valid, req_stall, req_data          | in
//   result  | rsp_valid, rsp_stall, rsp_data          | out
//   config  | csr_write_enable, csr_index, csr_write_data | in
// A tick passes through the back end as the pop, a table read, a multiply, 48 divider
// steps in bit-serial lanes and a result state that waits while the result is stalled.
// Loads and starts are handled as the back end pops them; unused opcodes are dropped at the front.
// Reset is synchronous and clears counters, queue and result valid; the table is not cleared.
// A two-entry queue lets requests arrive while a tick is in the divider or a result is stalled.
`timescale 1ns / 1ps
module keyframe_pose_interpolator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kfi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kfi_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [0:0]       csr_index,
   input  logic [4:0]       csr_write_data
);
   logic             cmd_valid;
   logic             cmd_pop;
   kfi_pkg::req_type cmd_data;

   kfi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   kfi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_data         (cmd_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );
endmodule

// ===== src/kfi_checker.sv =====
// Port-level checker for the keyframe pose interpolator, bound to the top level.
`timescale 1ns / 1ps
module kfi_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kfi_pkg::rsp_type rsp_data
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_known_valid: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_valid))
      else $error("result valid unknown");

   a_known_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_stall))
      else $error("request stall unknown");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
endmodule

bind keyframe_pose_interpolator_top kfi_checker u_kfi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/pose_checker.sv =====
// Checker: predicts interpolated poses from observed requests and compares them with results.
`timescale 1ns / 1ps
module pose_checker
   import kfi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [4:0] csr_write_data,
   output int         pose_errors,
   output int         poses_pending
);
   logic signed [COORD_BITS-1:0] key_coord [MAX_KEYS][N_COORD];
   logic [DUR_BITS-1:0]          key_dur [MAX_KEYS];
   int unsigned                  cur_key;
   int unsigned                  seg_frame;
   bit                           armed;
   bit                           loop_on;
   int unsigned                  key_total;
   rsp_type                      pose_queue [$];

   function automatic int unsigned keys_used();
      if (key_total == 0) return 1;
      if (key_total > MAX_KEYS) return MAX_KEYS;
      return key_total;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = 64'sd2147483647;
      lo = -hi - 1;
      if (v > hi) return hi[COORD_BITS-1:0];
      if (v < lo) return lo[COORD_BITS-1:0];
      return v[COORD_BITS-1:0];
   endfunction

   task automatic predict_pose(input req_type r);
      int unsigned n;
      int unsigned nxt;
      int unsigned d;
      longint c;
      longint diff;
      longint q;
      logic signed [COORD_BITS-1:0] coords [N_COORD];
      rsp_type p;
      case (op_type'(r.opcode))
         OP_LOAD: begin
            key_dur[r.key_index] = r.key_duration;
            key_coord[r.key_index][0] = r.view_x;
            key_coord[r.key_index][1] = r.view_y;
            key_coord[r.key_index][2] = r.view_z;
            key_coord[r.key_index][3] = r.target_x;
            key_coord[r.key_index][4] = r.target_y;
            key_coord[r.key_index][5] = r.target_z;
         end
         OP_START: begin
            cur_key = 0;
            seg_frame = 0;
            armed = 1;
         end
         OP_TICK: begin
            if (armed) begin
               n = keys_used();
               if (cur_key >= n) cur_key = 0;
               nxt = (cur_key == n - 1) ? 0 : cur_key + 1;
               d = (key_dur[nxt] == 0) ? 1 : key_dur[nxt];
               for (int j = 0; j < N_COORD; j++) begin
                  c = longint'(key_coord[cur_key][j]);
                  diff = longint'(key_coord[nxt][j]) - c;
                  q = (diff * longint'(seg_frame)) / longint'(d);
                  coords[j] = clamp_coord(c + q);
               end
               seg_frame++;
               if (seg_frame >= d) begin
                  seg_frame = 0;
                  cur_key = (cur_key + 1) % n;
                  if (!loop_on && cur_key == n - 1) armed = 0;
               end
               seg_frame &= 32'hFFFF;
               p.out_view_x = coords[0];
               p.out_view_y = coords[1];
               p.out_view_z = coords[2];
               p.out_target_x = coords[3];
               p.out_target_y = coords[4];
               p.out_target_z = coords[5];
               p.still_running = armed;
               pose_queue.insert(pose_queue.size(), p);
            end
         end
         default: ;
      endcase
   endtask

   function automatic int field_mismatch(string name, logic [31:0] e, logic [31:0] a);
      if (e === a) return 0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      return 1;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      int bad;
      if (reset) begin
         cur_key <= 0;
         seg_frame <= 0;
         armed <= 0;
         loop_on <= 0;
         key_total <= 1;
         pose_errors <= 0;
         poses_pending <= 0;
         pose_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_LOOP_ENABLE) loop_on = csr_write_data[0];
            else key_total = 32'(csr_write_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pose_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               pose_errors <= pose_errors + 1;
            end else begin
               e = pose_queue.pop_front();
               bad = field_mismatch("out_view_x", e.out_view_x, rsp_data.out_view_x)
                   + field_mismatch("out_view_y", e.out_view_y, rsp_data.out_view_y)
                   + field_mismatch("out_view_z", e.out_view_z, rsp_data.out_view_z)
                   + field_mismatch("out_target_x", e.out_target_x, rsp_data.out_target_x)
                   + field_mismatch("out_target_y", e.out_target_y, rsp_data.out_target_y)
                   + field_mismatch("out_target_z", e.out_target_z, rsp_data.out_target_z)
                   + field_mismatch("still_running", 32'(e.still_running),
                                    32'(rsp_data.still_running));
               if (bad != 0) pose_errors <= pose_errors + 1;
            end
         end
         if (req_valid && !req_stall) predict_pose(req_data);
         poses_pending <= pose_queue.size();
      end
   end
endmodule

// ===== test/tb_keyframe_pose_interpolator_top.sv =====
// Testbench top: drives requests and configuration, checks results through pose_checker.
`timescale 1ns / 1ps
module tb_keyframe_pose_interpolator_top;
   import kfi_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 0;
   logic [0:0] csr_index = CSR_LOOP_ENABLE;
   logic [4:0] csr_write_data = '0;
   int         pose_errors;
   int         poses_pending;
   int         quiet_cycles = 0;
   int         rx_cycle = 0;
   bit         no_gaps = 0;

   localparam int QUIET_LIMIT = 20000;

   always #5 clock = ~clock;

   keyframe_pose_interpolator_top dut (.*);

   pose_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle == 4000) begin
            rsp_stall = 1;
            repeat (500) @(negedge clock);
         end else if (rx_cycle > 30000 && rx_cycle < 45000) begin
            rsp_stall = 0;
         end else begin
            rsp_stall = ($urandom_range(99) < 34);
         end
      end
   end

   task automatic send(input req_type r);
      if (!no_gaps && $urandom_range(99) < 34) begin
         req_valid = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_data = r;
      req_valid = 1;
      while (req_stall) @(negedge clock);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [4:0] val);
      csr_index = idx;
      csr_write_data = val;
      csr_write_enable = 1;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   task automatic settle();
      while (poses_pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_load(input logic [3:0] idx, input logic [15:0] dur);
      req_type r;
      r.opcode = OP_LOAD;
      r.key_index = idx;
      r.key_duration = dur;
      r.view_x = pick_coord();
      r.view_y = pick_coord();
      r.view_z = pick_coord();
      r.target_x = pick_coord();
      r.target_y = pick_coord();
      r.target_z = pick_coord();
      return r;
   endfunction

   function automatic req_type make_op(input op_type op);
      req_type r;
      r = make_load(4'($urandom), 16'($urandom));
      r.opcode = op;
      return r;
   endfunction

   function automatic req_type random_request();
      int sel;
      logic [15:0] dur;
      sel = $urandom_range(99);
      if (sel < 20) begin
         if ($urandom_range(99) < 70) dur = 16'($urandom_range(6));
         else if ($urandom_range(99) < 85) dur = 16'($urandom_range(40));
         else dur = 16'($urandom);
         return make_load(4'($urandom), dur);
      end
      if (sel < 28) return make_op(OP_START);
      if (sel < 31) return make_op(OP_NONE);
      return make_op(OP_TICK);
   endfunction

   initial begin
      req_type r;
      logic [4:0] counts [7] = '{5'd16, 5'd2, 5'd1, 5'd16, 5'd0, 5'd31, 5'd5};
      repeat (10) @(negedge clock);
      reset = 0;
      write_csr(CSR_LOOP_ENABLE, 5'd0);
      write_csr(CSR_KEY_COUNT, 5'd16);

      r = make_load(4'd0, 16'd0);
      r.view_x = 32'h7FFFFFFF; r.view_y = 32'h7FFFFFFF; r.view_z = 32'h80000000;
      r.target_x = 32'h80000000; r.target_y = 32'h0; r.target_z = 32'hFFFFFFFF;
      send(r);
      r = make_load(4'd1, 16'd3);
      r.view_x = 32'h80000000; r.view_y = 32'h7FFFFFFF; r.view_z = 32'h7FFFFFFF;
      r.target_x = 32'h7FFFFFFF; r.target_y = 32'hFFFFFFFF; r.target_z = 32'h0;
      send(r);
      for (int k = 2; k < 16; k++)
         send(make_load(k[3:0], (k == 15) ? 16'hFFFF : k[15:0] % 3));
      send(make_op(OP_TICK));
      send(make_op(OP_START));
      repeat (4) send(make_op(OP_TICK));
      send(make_op(OP_NONE));
      send(make_op(OP_TICK));

      for (int ph = 0; ph < 7; ph++) begin
         settle();
         write_csr(CSR_LOOP_ENABLE, ph[0] ? 5'd1 : 5'd0);
         write_csr(CSR_KEY_COUNT, counts[ph]);
         send(make_op(OP_START));
         no_gaps = (ph == 3);
         repeat (235) send(random_request());
         no_gaps = 0;
      end

      while (poses_pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (pose_errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
